[hdl/camobj_pkg.sv]
// Shared types and constants for the camera object block parser.
`timescale 1ns / 1ps

package camobj_pkg;

  localparam logic [15:0] START_WORD    = 16'haa55;
  localparam logic [15:0] START_WORD_CC = 16'haa56;
  localparam logic [15:0] SWAPPED_WORD  = 16'h55aa;
  localparam logic [15:0] NO_WORD       = 16'hffff;

  localparam logic [2:0] NORMAL_FIELDS = 3'd5;
  localparam logic [2:0] CC_FIELDS     = 3'd6;
  localparam int         STORE_DEPTH   = 6;

  localparam logic [7:0] MAX_BLOCKS_RESET = 8'd100;

  localparam int DATA_BITS = 104;
  localparam int USER_BITS = 2;

  localparam logic [0:0] REG_MAX_BLOCKS = 1'b0;

  typedef enum logic [4:0] {
    PH_HUNT     = 5'b00001,
    PH_DROP     = 5'b00010,
    PH_CHECKSUM = 5'b00100,
    PH_FIELDS   = 5'b01000,
    PH_NEXT     = 5'b10000
  } phase_t;

  // packed so that bits [1:0] are the tuser flags and the rest is tdata
  typedef struct packed {
    logic [7:0]  block_index;
    logic [15:0] angle;
    logic [15:0] box_height;
    logic [15:0] box_width;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [15:0] signature;
    logic        color_code;
    logic        status;
  } result_t;

endpackage

[hdl/camera_object_block_parser.sv]
// Camera object block stream parser: byte-to-word pairing, frame hunt, block checksum.
`timescale 1ns / 1ps

// channel | dir | payload                                       | handshake
// s_*     | in  | tdata[7:0] rx_byte                            | tvalid/tready
// m_*     | out | tuser {color_code,status}, tdata block fields | tvalid/tready
// apb     | in  | max_blocks at byte address 0                  | pready always high
//
// One input item per cycle; each byte is parsed in the cycle it is accepted
// and any result is written to a two-entry output queue the same edge.
// s_tready drops only while both queue entries hold results not yet taken.
// Synchronous active-high rst returns to hunting with max_blocks = 100.

module camera_object_block_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] signature, [31:16] pos_x, [47:32] pos_y, [63:48] box_width,
  // [79:64] box_height, [95:80] angle, [103:96] block_index
  output logic [camobj_pkg::DATA_BITS-1:0] m_tdata,
  output logic [camobj_pkg::USER_BITS-1:0] m_tuser,  // [0] status, [1] color_code
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  max_blocks;
  logic        byte_phase, byte_phase_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] previous_word, previous_word_next;
  camobj_pkg::phase_t parse_phase, parse_phase_next;
  logic        frame_is_cc, frame_is_cc_next;
  logic [15:0] expected_sum, expected_sum_next;
  logic [15:0] running_sum, running_sum_next;
  logic [2:0]  field_index, field_index_next;
  logic [15:0] field_store [camobj_pkg::STORE_DEPTH];
  logic [15:0] field_store_next [camobj_pkg::STORE_DEPTH];
  logic [15:0] fields_new [camobj_pkg::STORE_DEPTH];
  logic [7:0]  good_count, good_count_next;

  logic        s_accept;
  logic [15:0] word;
  logic [15:0] sum_new;
  logic [2:0]  nfields;
  logic        open_req, open_cc;
  logic        push;
  camobj_pkg::result_t res;

  camobj_pkg::result_t head, head_next, skid, skid_next;
  logic        head_valid, head_valid_next, skid_valid, skid_valid_next;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == camobj_pkg::REG_MAX_BLOCKS) prdata = {24'd0, max_blocks};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_blocks <= camobj_pkg::MAX_BLOCKS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == camobj_pkg::REG_MAX_BLOCKS) begin
      max_blocks <= pwdata[7:0];
    end
  end

  assign s_tready = !skid_valid;
  assign s_accept = s_tvalid && s_tready;
  assign word     = {s_tdata, low_byte};
  assign sum_new  = running_sum + word;
  assign nfields  = frame_is_cc ? camobj_pkg::CC_FIELDS : camobj_pkg::NORMAL_FIELDS;

  always_comb begin
    for (int j = 0; j < camobj_pkg::STORE_DEPTH; j++) begin
      fields_new[j] = (field_index == 3'(j)) ? word : field_store[j];
    end
  end

  always_comb begin
    byte_phase_next    = byte_phase;
    low_byte_next      = low_byte;
    previous_word_next = previous_word;
    parse_phase_next   = parse_phase;
    frame_is_cc_next   = frame_is_cc;
    expected_sum_next  = expected_sum;
    running_sum_next   = running_sum;
    field_index_next   = field_index;
    field_store_next   = field_store;
    good_count_next    = good_count;
    open_req           = 1'b0;
    open_cc            = 1'b0;
    push               = 1'b0;

    res             = '0;
    res.status      = (expected_sum != sum_new);
    res.color_code  = frame_is_cc;
    res.signature   = fields_new[0];
    res.pos_x       = fields_new[1];
    res.pos_y       = fields_new[2];
    res.box_width   = fields_new[3];
    res.box_height  = fields_new[4];
    res.angle       = frame_is_cc ? fields_new[5] : 16'd0;
    res.block_index = good_count;

    if (s_accept) begin
      if (parse_phase == camobj_pkg::PH_DROP) begin
        parse_phase_next = camobj_pkg::PH_HUNT;
      end else if (!byte_phase) begin
        low_byte_next   = s_tdata;
        byte_phase_next = 1'b1;
      end else begin
        byte_phase_next = 1'b0;
        unique case (parse_phase)
          camobj_pkg::PH_HUNT: begin
            if (word == 16'd0 && previous_word == 16'd0) begin
              previous_word_next = camobj_pkg::NO_WORD;
            end else if (word == camobj_pkg::START_WORD &&
                         previous_word == camobj_pkg::START_WORD) begin
              open_req = 1'b1;
            end else if (word == camobj_pkg::START_WORD_CC &&
                         previous_word == camobj_pkg::START_WORD) begin
              open_req = 1'b1;
              open_cc  = 1'b1;
            end else begin
              if (word == camobj_pkg::SWAPPED_WORD) parse_phase_next = camobj_pkg::PH_DROP;
              previous_word_next = word;
            end
          end
          camobj_pkg::PH_CHECKSUM: begin
            if (word == camobj_pkg::START_WORD) begin
              open_req = 1'b1;
            end else if (word == camobj_pkg::START_WORD_CC) begin
              open_req = 1'b1;
              open_cc  = 1'b1;
            end else if (word == 16'd0) begin
              parse_phase_next   = camobj_pkg::PH_HUNT;
              previous_word_next = camobj_pkg::NO_WORD;
            end else begin
              expected_sum_next = word;
              running_sum_next  = 16'd0;
              field_index_next  = 3'd0;
              parse_phase_next  = camobj_pkg::PH_FIELDS;
            end
          end
          camobj_pkg::PH_FIELDS: begin
            field_store_next = fields_new;
            running_sum_next = sum_new;
            field_index_next = field_index + 3'd1;
            if (field_index + 3'd1 >= nfields) begin
              push             = 1'b1;
              parse_phase_next = camobj_pkg::PH_NEXT;
              if (expected_sum == sum_new) good_count_next = good_count + 8'd1;
            end
          end
          camobj_pkg::PH_NEXT: begin
            if (word == camobj_pkg::START_WORD || word == camobj_pkg::START_WORD_CC) begin
              frame_is_cc_next = (word == camobj_pkg::START_WORD_CC);
              if (good_count >= max_blocks) begin
                parse_phase_next   = camobj_pkg::PH_HUNT;
                previous_word_next = camobj_pkg::NO_WORD;
              end else begin
                parse_phase_next = camobj_pkg::PH_CHECKSUM;
              end
            end else begin
              parse_phase_next   = camobj_pkg::PH_HUNT;
              previous_word_next = camobj_pkg::NO_WORD;
            end
          end
          default: begin
            parse_phase_next   = camobj_pkg::PH_HUNT;
            previous_word_next = camobj_pkg::NO_WORD;
          end
        endcase

        if (open_req) begin
          frame_is_cc_next = open_cc;
          good_count_next  = 8'd0;
          if (max_blocks == 8'd0) begin
            parse_phase_next   = camobj_pkg::PH_HUNT;
            previous_word_next = camobj_pkg::NO_WORD;
          end else begin
            parse_phase_next = camobj_pkg::PH_CHECKSUM;
          end
        end
      end
    end
  end

  // two-entry output queue: head drives the port, skid catches the overflow
  always_comb begin
    head_next       = head;
    head_valid_next = head_valid;
    skid_next       = skid;
    skid_valid_next = skid_valid;
    if (head_valid && m_tready) begin
      if (skid_valid) begin
        head_next       = skid;
        skid_valid_next = 1'b0;
      end else begin
        head_valid_next = 1'b0;
      end
    end
    if (push) begin
      if (!head_valid_next) begin
        head_next       = res;
        head_valid_next = 1'b1;
      end else begin
        skid_next       = res;
        skid_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 1'b0;
      low_byte      <= 8'd0;
      previous_word <= camobj_pkg::NO_WORD;
      parse_phase   <= camobj_pkg::PH_HUNT;
      frame_is_cc   <= 1'b0;
      expected_sum  <= 16'd0;
      running_sum   <= 16'd0;
      field_index   <= 3'd0;
      good_count    <= 8'd0;
      head_valid    <= 1'b0;
      skid_valid    <= 1'b0;
      for (int j = 0; j < camobj_pkg::STORE_DEPTH; j++) field_store[j] <= 16'd0;
    end else begin
      byte_phase    <= byte_phase_next;
      low_byte      <= low_byte_next;
      previous_word <= previous_word_next;
      parse_phase   <= parse_phase_next;
      frame_is_cc   <= frame_is_cc_next;
      expected_sum  <= expected_sum_next;
      running_sum   <= running_sum_next;
      field_index   <= field_index_next;
      good_count    <= good_count_next;
      head_valid    <= head_valid_next;
      skid_valid    <= skid_valid_next;
      field_store   <= field_store_next;
    end
  end

  always_ff @(posedge clk) begin
    head <= head_next;
    skid <= skid_next;
  end

  assign m_tvalid = head_valid;
  assign m_tuser  = head[camobj_pkg::USER_BITS-1:0];
  assign m_tdata  = head[camobj_pkg::DATA_BITS+camobj_pkg::USER_BITS-1:camobj_pkg::USER_BITS];

endmodule
